>>> design/teq_pkg.sv
`timescale 1ns / 1ps

package teq_pkg;

    // Queue geometry
    localparam int CAPACITY  = 64;
    localparam int TIME_BITS = 32;
    localparam int CNT_W     = $clog2(CAPACITY + 1);

    // Port widths
    localparam int IN_DATA_W  = 80;   // 78 bits of fields, padded to whole bytes
    localparam int OUT_DATA_W = 88;   // 85 bits of fields, padded to whole bytes

    // Input kind codes
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_GET    = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2,
        STATUS_DUP   = 2'd3
    } status_t;

    typedef logic [TIME_BITS-1:0] time_t;

    // One stored event
    typedef struct packed {
        time_t       ev_time;
        logic [9:0]  ev_backoff;
        logic [15:0] ev_delay;
        logic [7:0]  ev_source;
        logic [7:0]  ev_dest;
        logic [3:0]  ev_type;
    } event_t;

    // Per-cycle commands broadcast to every cell
    typedef struct packed {
        logic cmp_en;   // latch compare flags against the new event
        logic ins_en;   // insert the new event in order
        logic get_en;   // shift everything one cell toward the head
    } cell_ctrl_t;

endpackage

>>> design/teq_cell.sv
`timescale 1ns / 1ps

module teq_cell
    import teq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  event_t     new_ev,     // event being inserted
    input  event_t     left_ev,    // neighbor nearer the head
    input  logic       left_take,  // neighbor nearer the head opens up on insert
    input  event_t     right_ev,   // neighbor nearer the tail
    input  logic       occ,        // this cell holds a live event
    output logic       take,       // this cell moves on insert
    output logic       eq,         // live event with the same timestamp
    output event_t     ev
);

    event_t ev_reg;
    logic   gt_reg;
    logic   eq_reg;

    // Compare flags, latched in the compare state, ahead of the shift
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gt_reg <= 1'b0;
            eq_reg <= 1'b0;
        end
        else if (ctrl.cmp_en)
        begin
            gt_reg <= ev_reg.ev_time > new_ev.ev_time;
            eq_reg <= ev_reg.ev_time == new_ev.ev_time;
        end
    end

    // Stored event: shift toward the tail on insert, toward the head on get
    always_ff @(posedge clk)
    begin
        if (ctrl.ins_en && take)
        begin
            ev_reg <= left_take ? left_ev : new_ev;
        end
        else if (ctrl.get_en)
        begin
            ev_reg <= right_ev;
        end
    end

    assign take = !occ || gt_reg;
    assign eq   = occ && eq_reg;
    assign ev   = ev_reg;

endmodule

>>> design/time_ordered_event_queue_unit.sv
`timescale 1ns / 1ps
// Time-ordered event queue: a sorted list of up to CAPACITY events held in a
// row of cells, earliest timestamp at cell 0.
// Input stream (s_*): tuser is the kind, 0 insert and 1 get; tdata carries the
// event. One result beat leaves on the output stream (m_*) for every input
// beat: tuser is the status (ok, empty, full, duplicate timestamp), tdata the
// removed event and the occupancy after the operation.
// Each item passes accept, a compare cycle in which every cell
// latches its timestamp compare against the new event, and a commit cycle in
// which the cells shift one place in step and the result is registered. The
// next item is accepted the cycle after commit, so no new item is taken
// before the last one has committed.
// When the receiver stalls, the finished result waits in the output register;
// a following item is accepted and compared, and its commit waits until the
// output register is free.
// Reset empties the queue (the fill count goes to zero) and drops any result
// in flight. Stored event contents are not cleared; only entries below the
// fill count are ever read.

module time_ordered_event_queue_unit
    import teq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // ev_time[31:0], ev_backoff[41:32], ev_delay[57:42], ev_source[65:58],
    // ev_dest[73:66], ev_type[77:74], zero pad
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // kind[0]
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // out_time[31:0], out_backoff[41:32], out_delay[57:42], out_source[65:58],
    // out_dest[73:66], out_type[77:74], occupancy[84:78], zero pad
    output logic [OUT_DATA_W-1:0] m_tdata,
    // status[1:0]
    output logic [1:0]            m_tuser
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_CMP   = 3'b010,
        ST_APPLY = 3'b100
    } state_t;

    state_t     state_reg, state_next;
    logic       kind_reg;
    event_t     cmd_reg;
    logic [CNT_W-1:0] count_reg, count_next;

    logic       out_valid_reg, out_valid_next;
    status_t    out_status_reg, out_status_next;
    event_t     out_ev_reg, out_ev_next;
    logic [6:0] out_occ_reg, out_occ_next;

    cell_ctrl_t ctrl;
    event_t     cell_ev [CAPACITY];
    logic [CAPACITY-1:0] take_vec;
    logic [CAPACITY-1:0] eq_vec;
    logic [CAPACITY-1:0] occ_vec;

    logic in_fire;
    logic commit;
    logic dup;
    logic full;
    logic empty;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign commit   = (state_reg == ST_APPLY) && (!out_valid_reg || m_tready);
    assign dup      = |eq_vec;
    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign empty    = (count_reg == '0);

    // Incoming command
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            kind_reg           <= s_tuser;
            cmd_reg.ev_time    <= time_t'(s_tdata[31:0]);
            cmd_reg.ev_backoff <= s_tdata[41:32];
            cmd_reg.ev_delay   <= s_tdata[57:42];
            cmd_reg.ev_source  <= s_tdata[65:58];
            cmd_reg.ev_dest    <= s_tdata[73:66];
            cmd_reg.ev_type    <= s_tdata[77:74];
        end
    end

    // Cell commands
    always_comb
    begin
        ctrl.cmp_en = (state_reg == ST_CMP);
        ctrl.ins_en = commit && (kind_reg == KIND_INSERT) && !dup && !full;
        ctrl.get_en = commit && (kind_reg == KIND_GET) && !empty;
    end

    // Cell chain
    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            event_t left_ev;
            logic   left_take;
            event_t right_ev;

            if (i == 0)
            begin : g_head
                assign left_ev   = cmd_reg;
                assign left_take = 1'b0;
            end
            else
            begin : g_body
                assign left_ev   = cell_ev[i-1];
                assign left_take = take_vec[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_tail
                assign right_ev = cell_ev[i];
            end
            else
            begin : g_mid
                assign right_ev = cell_ev[i+1];
            end

            assign occ_vec[i] = count_reg > CNT_W'(i);

            teq_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .new_ev    (cmd_reg),
                .left_ev   (left_ev),
                .left_take (left_take),
                .right_ev  (right_ev),
                .occ       (occ_vec[i]),
                .take      (take_vec[i]),
                .eq        (eq_vec[i]),
                .ev        (cell_ev[i])
            );
        end
    endgenerate

    // Sequencer, fill count and result
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_ev_next     = out_ev_reg;
        out_occ_next    = out_occ_reg;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                if (commit)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    out_ev_next    = '0;
                    if (kind_reg == KIND_INSERT)
                    begin
                        priority if (dup)
                        begin
                            out_status_next = STATUS_DUP;
                        end
                        else if (full)
                        begin
                            out_status_next = STATUS_FULL;
                        end
                        else
                        begin
                            out_status_next = STATUS_OK;
                            count_next      = count_reg + CNT_W'(1);
                        end
                    end
                    else if (empty)
                    begin
                        out_status_next = STATUS_EMPTY;
                    end
                    else
                    begin
                        out_status_next = STATUS_OK;
                        out_ev_next     = cell_ev[0];
                        count_next      = count_reg - CNT_W'(1);
                    end
                    out_occ_next = 7'(count_next);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_ev_reg     <= out_ev_next;
        out_occ_reg    <= out_occ_next;
    end

    // Output stream
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {3'b000,
                       out_occ_reg,
                       out_ev_reg.ev_type,
                       out_ev_reg.ev_dest,
                       out_ev_reg.ev_source,
                       out_ev_reg.ev_delay,
                       out_ev_reg.ev_backoff,
                       32'(out_ev_reg.ev_time)};

    // Checks
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("fill count beyond capacity");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.ins_en |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("insert did not grow the fill count");

    a_get_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.get_en |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("get did not shrink the fill count");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_APPLY))
        else $error("result appeared outside commit");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |=> out_valid_reg && $stable(out_status_reg))
        else $error("stalled result was overwritten");

endmodule
